/* hdl/hbs_pkg.sv */
// Shared types and constants of the hierarchical bitmap set.
`default_nettype none

package hbs_pkg;

	// Word geometry: 64 leaf words of 64 bits under one summary word.
	localparam int unsigned WORD_BITS = 64;
	localparam int unsigned WORD_AW   = 6;
	localparam int unsigned POS_W     = 2 * WORD_AW;
	localparam int unsigned IDX_W     = 14;
	localparam int unsigned SIZE_W    = 13;

	// Largest number of indices the store holds.
	localparam logic [SIZE_W-1:0] SET_SIZE = 13'd4096;

	// Answer of a downward search that finds nothing.
	localparam logic [IDX_W-1:0] IDX_NONE = 14'h3FFF;

	// Request codes.
	localparam logic [2:0] CMD_INSERT = 3'd0;
	localparam logic [2:0] CMD_ERASE  = 3'd1;
	localparam logic [2:0] CMD_NEXT   = 3'd2;
	localparam logic [2:0] CMD_PREV   = 3'd3;
	localparam logic [2:0] CMD_TEST   = 3'd4;

	// Result of one pass of the bit scanner.
	typedef struct packed {
		logic               found;
		logic [WORD_AW-1:0] pos;
	} scan_res_t;

endpackage

`default_nettype wire

/* hdl/hbs_scan.sv */
// Shared 64-bit scanner that finds the lowest or the highest set bit of a word.
`default_nettype none

module hbs_scan (
	input  logic [hbs_pkg::WORD_BITS-1:0] word,
	input  logic                          dir_high,
	output hbs_pkg::scan_res_t            res
);

	// Priority encoder: the last hit in loop order wins.
	always_comb begin
		res.found = |word;
		res.pos   = '0;
		if (dir_high) begin
			for (int i = 0; i < hbs_pkg::WORD_BITS; i++) begin
				if (word[i]) begin
					res.pos = hbs_pkg::WORD_AW'(i);
				end
			end
		end else begin
			for (int i = hbs_pkg::WORD_BITS - 1; i >= 0; i--) begin
				if (word[i]) begin
					res.pos = hbs_pkg::WORD_AW'(i);
				end
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/hierarchical_bitmap_set_top.sv */
// Hierarchical bitmap set: top level with sequencer, leaf memory and summary word.
//
// A request enters on in_valid/in_stall with cmd and index; it is taken at an
// edge where in_valid is high and in_stall is low. in_stall stays high while a
// request is in work. Next, prev and test give one result on out_valid/out_stall
// (found_index, member_flag); insert, erase and unknown codes give none.
// A search scans the leaf word at its start and, when that holds no hit, the
// summary word and then the leaf word that the summary points to; a test reads
// one leaf word, an update reads and writes back one, and a request answered
// from its index alone, an ignored update or an unknown code reads no leaf word.
// A result is loaded into the output register at the edge at which the block
// becomes ready again. The leaf memory has one read port with a registered
// output, and one shared scanner serves both scans.
// The output register lets a new request be taken while a result waits; a
// further result waits inside the block until the receiver drops out_stall.
// Reset clears the set at once through one valid flag per leaf word, clears the
// summary word and sets size_in_use to 4096. size_in_use is to be written through
// cfg_wr_en/cfg_wr_data only while the block is idle; the block does not enforce it.
`default_nettype none

module hierarchical_bitmap_set_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [2:0]                          cmd,
	input  logic signed [hbs_pkg::IDX_W-1:0]    index,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [hbs_pkg::IDX_W-1:0]    found_index,
	output logic                                member_flag,
	input  logic                                cfg_wr_en,
	input  logic [hbs_pkg::SIZE_W-1:0]          cfg_wr_data
);

	localparam int unsigned WB  = hbs_pkg::WORD_BITS;
	localparam int unsigned AW  = hbs_pkg::WORD_AW;
	localparam int unsigned PW  = hbs_pkg::POS_W;
	localparam int unsigned IW  = hbs_pkg::IDX_W;
	localparam int unsigned SW  = hbs_pkg::SIZE_W;
	localparam logic [WB-1:0] ONES = '1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_TEST,
		ST_SCAN_LEAF,
		ST_SCAN_SUM,
		ST_EMIT
	} state_t;

	state_t              state_q;
	logic [2:0]          cmd_q;
	logic [AW-1:0]       w_q;
	logic [AW-1:0]       b_q;
	logic [WB-1:0]       summary_q;
	logic [IW-1:0]       res_idx_q;
	logic                res_flag_q;
	logic                out_valid_q;
	logic [IW-1:0]       out_idx_q;
	logic                out_flag_q;
	logic [SW-1:0]       size_q;

	logic [WB-1:0]       mem_q [WB];
	logic [WB-1:0]       vld_q;
	logic [WB-1:0]       rd_data_q;
	logic                rd_vld_q;

	logic [SW-1:0]       n_eff;
	logic [SW-1:0]       n_m1;
	logic                idx_neg;
	logic                in_range;
	logic                above;
	logic [PW-1:0]       start_pos;
	logic                accept;
	logic                out_free;

	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic                mem_we;
	logic [WB-1:0]       wr_data;

	logic [WB-1:0]       leaf_word;
	logic [WB-1:0]       bit_sel;
	logic                dir_high;
	logic [WB-1:0]       scan_word;
	hbs_pkg::scan_res_t  scan;
	logic [PW-1:0]       hit_pos;
	logic [IW-1:0]       next_hit;
	logic [IW-1:0]       none_res;

	// Size in use, clamped to 1 .. SET_SIZE.
	always_comb begin
		if (size_q == '0) begin
			n_eff = SW'(1);
		end else if (size_q > hbs_pkg::SET_SIZE) begin
			n_eff = hbs_pkg::SET_SIZE;
		end else begin
			n_eff = size_q;
		end
		n_m1 = n_eff - SW'(1);
	end

	// Decode of the incoming request.
	assign idx_neg  = index[IW-1];
	assign in_range = !idx_neg && ($unsigned(index) < {1'b0, n_eff});
	assign above    = !idx_neg && !in_range;
	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// Search start: next clamps up to zero, prev clamps down to size minus one.
	always_comb begin
		if (cmd == hbs_pkg::CMD_PREV && above) begin
			start_pos = n_m1[PW-1:0];
		end else if (cmd == hbs_pkg::CMD_NEXT && idx_neg) begin
			start_pos = '0;
		end else begin
			start_pos = index[PW-1:0];
		end
	end

	// Leaf word as read; a word never written reads as zero.
	assign leaf_word = rd_vld_q ? rd_data_q : '0;
	assign bit_sel   = WB'(1) << b_q;
	assign dir_high  = (cmd_q == hbs_pkg::CMD_PREV);

	// Input of the shared scanner: masked summary or masked leaf word.
	always_comb begin
		if (state_q == ST_SCAN_SUM) begin
			scan_word = dir_high ? (summary_q & ~(ONES << w_q))
			                     : (summary_q & ((ONES << w_q) << 1));
		end else begin
			scan_word = dir_high ? (leaf_word & (ONES >> (~b_q)))
			                     : (leaf_word & (ONES << b_q));
		end
	end

	hbs_scan u_scan (
		.word     (scan_word),
		.dir_high (dir_high),
		.res      (scan)
	);

	// Candidate answers of a leaf scan and of a failed search.
	assign hit_pos  = {w_q, scan.pos};
	assign next_hit = ({1'b0, hit_pos} < n_eff) ? {2'b00, hit_pos} : {1'b0, n_eff};
	assign none_res = dir_high ? hbs_pkg::IDX_NONE : {1'b0, n_eff};

	// Memory read and write requests.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = start_pos[PW-1:AW];
		if (state_q == ST_IDLE && accept) begin
			rd_en = (cmd == hbs_pkg::CMD_NEXT && !above)
			     || (cmd == hbs_pkg::CMD_PREV && !idx_neg)
			     || ((cmd == hbs_pkg::CMD_INSERT || cmd == hbs_pkg::CMD_ERASE
			         || cmd == hbs_pkg::CMD_TEST) && in_range);
		end else if (state_q == ST_SCAN_SUM && scan.found) begin
			rd_en   = 1'b1;
			rd_addr = scan.pos;
		end
	end

	assign mem_we  = (state_q == ST_UPDATE);
	assign wr_data = (cmd_q == hbs_pkg::CMD_INSERT) ? (leaf_word | bit_sel)
	                                                : (leaf_word & ~bit_sel);

	// Leaf memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[w_q] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// Valid flag per leaf word and the flag of the word last read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (mem_we) begin
				vld_q[w_q] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// Size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= hbs_pkg::SET_SIZE;
		end else if (cfg_wr_en) begin
			size_q <= cfg_wr_data;
		end
	end

	// Sequencer with the summary word and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= hbs_pkg::CMD_INSERT;
			w_q         <= '0;
			b_q         <= '0;
			summary_q   <= '0;
			res_idx_q   <= '0;
			res_flag_q  <= 1'b0;
			out_valid_q <= 1'b0;
			out_idx_q   <= '0;
			out_flag_q  <= 1'b0;
		end else begin
			// The output register empties when taken, unless a new result replaces it.
			if (out_valid_q && !out_stall && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q      <= cmd;
						w_q        <= start_pos[PW-1:AW];
						b_q        <= start_pos[AW-1:0];
						res_flag_q <= 1'b0;
						unique case (cmd)
							hbs_pkg::CMD_INSERT, hbs_pkg::CMD_ERASE: begin
								if (in_range) begin
									state_q <= ST_UPDATE;
								end
							end
							hbs_pkg::CMD_TEST: begin
								res_idx_q <= '0;
								state_q   <= in_range ? ST_TEST : ST_EMIT;
							end
							hbs_pkg::CMD_NEXT: begin
								if (above) begin
									res_idx_q <= {1'b0, n_eff};
									state_q   <= ST_EMIT;
								end else begin
									state_q <= ST_SCAN_LEAF;
								end
							end
							hbs_pkg::CMD_PREV: begin
								if (idx_neg) begin
									res_idx_q <= hbs_pkg::IDX_NONE;
									state_q   <= ST_EMIT;
								end else begin
									state_q <= ST_SCAN_LEAF;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_UPDATE: begin
					summary_q[w_q] <= (cmd_q == hbs_pkg::CMD_INSERT) || (wr_data != '0);
					state_q        <= ST_IDLE;
				end
				ST_TEST: begin
					res_flag_q <= leaf_word[b_q];
					state_q    <= ST_EMIT;
				end
				ST_SCAN_LEAF: begin
					if (scan.found) begin
						res_idx_q <= dir_high ? {2'b00, hit_pos} : next_hit;
						state_q   <= ST_EMIT;
					end else begin
						state_q <= ST_SCAN_SUM;
					end
				end
				ST_SCAN_SUM: begin
					if (scan.found) begin
						w_q     <= scan.pos;
						b_q     <= dir_high ? ~AW'(0) : AW'(0);
						state_q <= ST_SCAN_LEAF;
					end else begin
						res_idx_q <= none_res;
						state_q   <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_idx_q   <= res_idx_q;
						out_flag_q  <= res_flag_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign found_index = $signed(out_idx_q);
	assign member_flag = out_flag_q;

	// The summary bit of a written leaf word says whether that word is non-empty.
	a_summary_tracks_leaf: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> (summary_q[$past(w_q)] == ($past(wr_data) != '0)))
		else $error("summary bit does not match the written leaf word");

	// A leaf word chosen from the summary word is never empty.
	a_summary_read_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN_SUM && rd_en) |=> (rd_vld_q && rd_data_q != '0))
		else $error("leaf word picked through the summary is empty");

	// An upward search never answers beyond the size in use.
	a_next_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && cmd_q == hbs_pkg::CMD_NEXT)
		|-> (!res_idx_q[IW-1] && res_idx_q <= {1'b0, n_eff}))
		else $error("next result above the size in use");

	// A downward search answers below the size in use, or none.
	a_prev_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && cmd_q == hbs_pkg::CMD_PREV)
		|-> (res_idx_q == hbs_pkg::IDX_NONE || res_idx_q < {1'b0, n_eff}))
		else $error("prev result outside the size in use");

	// A waiting result is never overwritten before the receiver takes it.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(out_idx_q)
		&& $stable(out_flag_q)))
		else $error("waiting result overwritten");

endmodule

`default_nettype wire

/* tb/hierarchical_bitmap_set_checker.sv */
// Checker for the hierarchical bitmap set: predicts each answer and compares it with the result.
`timescale 1ns / 1ps

module hierarchical_bitmap_set_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic [2:0]                       cmd,
	input  logic signed [hbs_pkg::IDX_W-1:0] index,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic signed [hbs_pkg::IDX_W-1:0] found_index,
	input  logic                             member_flag,
	input  logic                             cfg_wr_en,
	input  logic [hbs_pkg::SIZE_W-1:0]       cfg_wr_data,
	output int                               mismatch_count,
	output int                               answers_checked,
	output int                               answers_waiting
);

	localparam int LEAF_BITS  = int'(hbs_pkg::WORD_BITS);
	localparam int FIFO_DEPTH = 16;

	typedef struct packed {
		logic signed [hbs_pkg::IDX_W-1:0] found;
		logic                             member;
	} answer_t;

	// Shadow copy of the set and of the size register.
	logic [hbs_pkg::WORD_BITS-1:0] member_words [hbs_pkg::WORD_BITS];
	logic [hbs_pkg::SIZE_W-1:0]    size_reg;

	// Answers predicted for accepted requests, oldest first.
	answer_t answer_fifo [FIFO_DEPTH];
	int      fifo_head;
	int      fifo_tail;
	int      fifo_level;

	// A size of zero behaves as one and anything above the store behaves as the full store.
	function automatic int clamp_size(input logic [hbs_pkg::SIZE_W-1:0] s);
		int n;
		n = int'(s);
		if (n < 1)
			n = 1;
		if (n > int'(hbs_pkg::SET_SIZE))
			n = int'(hbs_pkg::SET_SIZE);
		return n;
	endfunction

	function automatic bit is_member(input int j);
		return member_words[j / LEAF_BITS][j % LEAF_BITS];
	endfunction

	// Least member at or above i that lies below n; n when there is none.
	function automatic int scan_up(input int i, input int n);
		int start;
		start = (i < 0) ? 0 : i;
		for (int j = start; j < n; j++) begin
			if (is_member(j))
				return j;
		end
		return n;
	endfunction

	// Greatest member at or below i, searching no higher than n - 1; -1 when there is none.
	function automatic int scan_down(input int i, input int n);
		int start;
		start = (i >= n) ? n - 1 : i;
		for (int j = start; j >= 0; j--) begin
			if (is_member(j))
				return j;
		end
		return -1;
	endfunction

	// Applies one request to the shadow set and works out the answer it produces, if any.
	task automatic apply_set_command(input logic [2:0] c, input int i, output bit has_answer,
			output answer_t ans);
		int n;
		int r;
		bit in_range;
		n          = clamp_size(size_reg);
		in_range   = (i >= 0) && (i < n);
		has_answer = 1'b0;
		ans        = '0;
		case (c)
			hbs_pkg::CMD_INSERT: begin
				if (in_range)
					member_words[i / LEAF_BITS][i % LEAF_BITS] = 1'b1;
			end
			hbs_pkg::CMD_ERASE: begin
				if (in_range)
					member_words[i / LEAF_BITS][i % LEAF_BITS] = 1'b0;
			end
			hbs_pkg::CMD_NEXT: begin
				r          = scan_up(i, n);
				has_answer = 1'b1;
				ans.found  = r[hbs_pkg::IDX_W-1:0];
			end
			hbs_pkg::CMD_PREV: begin
				r          = scan_down(i, n);
				has_answer = 1'b1;
				ans.found  = r[hbs_pkg::IDX_W-1:0];
			end
			hbs_pkg::CMD_TEST: begin
				has_answer = 1'b1;
				if (in_range)
					ans.member = is_member(i);
			end
			default: begin
				// Spare codes leave the set alone and give no answer.
			end
		endcase
	endtask

	// Watch both channels and the size register at every edge.
	always @(posedge clk or negedge arst_n) begin : watch_channels
		answer_t got;
		answer_t want;
		answer_t predicted;
		bit      has_answer;
		if (!arst_n) begin
			for (int w = 0; w < LEAF_BITS; w++)
				member_words[w] = '0;
			size_reg        = hbs_pkg::SET_SIZE;
			fifo_head       = 0;
			fifo_tail       = 0;
			fifo_level      = 0;
			mismatch_count  = 0;
			answers_checked = 0;
			answers_waiting <= 0;
		end else begin
			// A result taken at this edge always belongs to an earlier request.
			if (out_valid && !out_stall) begin
				got.found  = found_index;
				got.member = member_flag;
				if (fifo_level == 0) begin
					mismatch_count++;
					$display("%0t: result with no request: expected none, got %0d / %0b",
						$time, got.found, got.member);
				end else begin
					want       = answer_fifo[fifo_head];
					fifo_head  = (fifo_head + 1) % FIFO_DEPTH;
					fifo_level--;
					answers_checked++;
					if (got.found !== want.found) begin
						mismatch_count++;
						$display("%0t: found_index expected %0d, got %0d", $time, want.found,
							got.found);
					end
					if (got.member !== want.member) begin
						mismatch_count++;
						$display("%0t: member_flag expected %0b, got %0b", $time, want.member,
							got.member);
					end
				end
			end
			if (cfg_wr_en)
				size_reg = cfg_wr_data;
			if (in_valid && !in_stall) begin
				apply_set_command(cmd, int'(index), has_answer, predicted);
				if (has_answer) begin
					if (fifo_level == FIFO_DEPTH) begin
						mismatch_count++;
						$display("%0t: answers waiting expected at most %0d, got %0d",
							$time, FIFO_DEPTH, fifo_level + 1);
					end else begin
						answer_fifo[fifo_tail] = predicted;
						fifo_tail              = (fifo_tail + 1) % FIFO_DEPTH;
						fifo_level++;
					end
				end
			end
			answers_waiting <= fifo_level;
		end
	end

endmodule

/* tb/hierarchical_bitmap_set_top_tb.sv */
// Testbench top for the hierarchical bitmap set: drives requests and size settings and gives the verdict.
`timescale 1ns / 1ps

module hierarchical_bitmap_set_top_tb;

	localparam int         CYCLE_LIMIT     = 400000;
	localparam int         SETTLE_CYCLES   = 12;
	localparam int         LONG_HOLD       = 400;
	localparam int         IDX_SPAN        = 1 << hbs_pkg::IDX_W;
	localparam int         SIZE_SPAN       = 1 << hbs_pkg::SIZE_W;
	localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

	typedef enum int { MIX_SPARSE, MIX_DENSE, MIX_CLEAR } mix_t;

	logic                             clk         = 1'b0;
	logic                             arst_n      = 1'b0;
	logic                             in_valid    = 1'b0;
	logic                             in_stall;
	logic [2:0]                       cmd         = hbs_pkg::CMD_INSERT;
	logic signed [hbs_pkg::IDX_W-1:0] index       = '0;
	logic                             out_valid;
	logic                             out_stall   = 1'b0;
	logic signed [hbs_pkg::IDX_W-1:0] found_index;
	logic                             member_flag;
	logic                             cfg_wr_en   = 1'b0;
	logic [hbs_pkg::SIZE_W-1:0]       cfg_wr_data = '0;

	int mismatch_count;
	int answers_checked;
	int answers_waiting;
	int cycle_count   = 0;
	int requests_sent = 0;
	int sizes_used    = 0;
	int hold_asked    = 0;
	int size_now      = 4096;
	bit tx_steady     = 1'b0;
	bit rx_steady     = 1'b0;

	hierarchical_bitmap_set_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.index       (index),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found_index (found_index),
		.member_flag (member_flag),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	hierarchical_bitmap_set_checker answer_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.cmd             (cmd),
		.index           (index),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.found_index     (found_index),
		.member_flag     (member_flag),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.mismatch_count  (mismatch_count),
		.answers_checked (answers_checked),
		.answers_waiting (answers_waiting)
	);

	always #2 clk = ~clk;

	// Watchdog: ends the run if the block hangs.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Run stopped by the watchdog after %0d cycles.", cycle_count);
		$display("hierarchical_bitmap_set_top: mismatch");
		$finish;
	end

	// Result side: stalls a random number of cycles before each result, or one long stretch on demand.
	initial begin : result_side
		int k;
		int holds_served;
		holds_served = 0;
		forever begin
			if (hold_asked > holds_served) begin
				k = LONG_HOLD;
				holds_served++;
			end else begin
				k = rx_steady ? 0 : $urandom_range(0, 11);
			end
			if (k > 0) begin
				out_stall <= 1'b1;
				repeat (k) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Offers one request after a random gap and waits until it is taken.
	task automatic send_request(input logic [2:0] c, input int i);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		index    <= i[hbs_pkg::IDX_W-1:0];
		do @(posedge clk); while (in_stall);
		requests_sent++;
	endtask

	// Waits for every expected answer, then lets trailing updates finish inside the block.
	task automatic drain_answers();
		in_valid <= 1'b0;
		do @(posedge clk); while (answers_waiting != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_size(input logic [hbs_pkg::SIZE_W-1:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		size_now = int'(v);
		if (size_now < 1)
			size_now = 1;
		if (size_now > int'(hbs_pkg::SET_SIZE))
			size_now = int'(hbs_pkg::SET_SIZE);
		sizes_used++;
	endtask

	// Command mix: updates are weighted by the phase; searches, tests and spare codes fill the rest.
	function automatic logic [2:0] pick_command(input mix_t mix);
		int r;
		int ins_w;
		int era_w;
		logic [2:0] c;
		r = $urandom_range(0, 99);
		case (mix)
			MIX_SPARSE: begin
				ins_w = 12;
				era_w = 6;
			end
			MIX_DENSE: begin
				ins_w = 40;
				era_w = 10;
			end
			default: begin
				ins_w = 10;
				era_w = 45;
			end
		endcase
		if (r < ins_w) begin
			c = hbs_pkg::CMD_INSERT;
		end else if (r < ins_w + era_w) begin
			c = hbs_pkg::CMD_ERASE;
		end else if (r >= 97) begin
			c = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
		end else begin
			r = $urandom_range(0, 9);
			c = (r < 4) ? hbs_pkg::CMD_NEXT : (r < 8) ? hbs_pkg::CMD_PREV : hbs_pkg::CMD_TEST;
		end
		return c;
	endfunction

	// Index mix: a working window, word edges, the size edge, zero, minus one, in-size and raw values.
	function automatic int pick_index(input int n, input int hot_lo, input int hot_w);
		int r;
		int v;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			v = hot_lo + $urandom_range(0, hot_w - 1);
		end else if (r < 64) begin
			v = $urandom_range(0, 3);
			v = $urandom_range(0, 63) * 64 + ((v < 2) ? v : v + 60);
		end else if (r < 74) begin
			v = n - 2 + $urandom_range(0, 3);
		end else if (r < 80) begin
			v = $urandom_range(0, 1) ? -1 : 0;
		end else if (r < 90) begin
			v = $urandom_range(0, n - 1);
		end else begin
			v = $urandom_range(0, IDX_SPAN - 1);
			if (v >= IDX_SPAN / 2)
				v -= IDX_SPAN;
		end
		return v;
	endfunction

	// One random phase at a given size; the window and the idling moods move every 40 requests.
	task automatic run_phase(input logic [hbs_pkg::SIZE_W-1:0] sz, input int count,
			input mix_t mix, input bit long_hold);
		int hot_lo;
		int hot_w;
		drain_answers();
		write_size(sz);
		if (long_hold) begin
			hold_asked++;
			tx_steady = 1'b1;
		end
		for (int k = 0; k < count; k++) begin
			if (k % 40 == 0) begin
				hot_lo = $urandom_range(0, size_now - 1);
				hot_w  = (mix == MIX_SPARSE) ? size_now - hot_lo : 1 + $urandom_range(0, 127);
				if (hot_lo + hot_w > size_now)
					hot_w = size_now - hot_lo;
				if (!long_hold || k >= 40) begin
					tx_steady = ($urandom_range(0, 3) == 0);
					rx_steady = ($urandom_range(0, 3) == 0);
				end
			end
			send_request(pick_command(mix), pick_index(size_now, hot_lo, hot_w));
		end
	endtask

	initial begin : stimulus
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Searches and a test on the empty set at the reset size.
		send_request(hbs_pkg::CMD_NEXT, -1);
		send_request(hbs_pkg::CMD_PREV, 4096);
		send_request(hbs_pkg::CMD_TEST, 0);
		// Updates at both ends and across a word edge, plus ones outside the size that are ignored.
		send_request(hbs_pkg::CMD_INSERT, 0);
		send_request(hbs_pkg::CMD_INSERT, 63);
		send_request(hbs_pkg::CMD_INSERT, 64);
		send_request(hbs_pkg::CMD_INSERT, 4095);
		send_request(hbs_pkg::CMD_INSERT, -1);
		send_request(hbs_pkg::CMD_INSERT, 4096);
		send_request(hbs_pkg::CMD_ERASE, -8192);
		// Searches clamped from below zero and from above the size, and through the summary word.
		send_request(hbs_pkg::CMD_NEXT, -8192);
		send_request(hbs_pkg::CMD_NEXT, 1);
		send_request(hbs_pkg::CMD_NEXT, 65);
		send_request(hbs_pkg::CMD_NEXT, 4096);
		send_request(hbs_pkg::CMD_NEXT, 8191);
		send_request(hbs_pkg::CMD_PREV, 8191);
		send_request(hbs_pkg::CMD_PREV, 62);
		send_request(hbs_pkg::CMD_PREV, -1);
		send_request(hbs_pkg::CMD_TEST, 63);
		send_request(hbs_pkg::CMD_TEST, 4096);
		send_request(hbs_pkg::CMD_TEST, -1);
		send_request(hbs_pkg::CMD_ERASE, 63);
		send_request(hbs_pkg::CMD_NEXT, 1);
		send_request(hbs_pkg::CMD_PREV, 4094);
		send_request(CMD_SPARE_FIRST, 8191);
		send_request(CMD_SPARE_LAST, -8192);

		// Random phases; members left beyond a reduced size stay stored across them.
		run_phase(13'd4096, 200, MIX_SPARSE, 1'b0);
		run_phase(13'd64, 150, MIX_DENSE, 1'b0);
		run_phase(13'd1, 60, MIX_DENSE, 1'b0);
		run_phase(13'd0, 40, MIX_CLEAR, 1'b0);
		run_phase(13'd8191, 200, MIX_SPARSE, 1'b1);
		run_phase(13'd65, 120, MIX_DENSE, 1'b0);
		run_phase(13'd4095, 200, MIX_SPARSE, 1'b0);
		run_phase(13'd2, 60, MIX_DENSE, 1'b0);
		run_phase(13'd130, 150, MIX_CLEAR, 1'b0);
		run_phase(hbs_pkg::SIZE_W'($urandom_range(1, 4096)), 100, MIX_DENSE, 1'b0);
		run_phase(hbs_pkg::SIZE_W'($urandom_range(0, SIZE_SPAN - 1)), 100, MIX_SPARSE, 1'b0);
		run_phase(hbs_pkg::SIZE_W'($urandom_range(1, 4096)), 100, MIX_CLEAR, 1'b0);
		run_phase(13'd4096, 150, MIX_SPARSE, 1'b0);
		run_phase(13'd700, 120, MIX_CLEAR, 1'b0);
		drain_answers();

		$display("Sent %0d requests over %0d sizes, with random gaps, stalls and one long hold.",
			requests_sent, sizes_used);
		$display("Checked %0d answers against the predicted set.", answers_checked);
		if (mismatch_count == 0 && answers_waiting == 0)
			$display("hierarchical_bitmap_set_top: match");
		else
			$display("hierarchical_bitmap_set_top: mismatch");
		$finish;
	end

endmodule

/* files.f */
hdl/hbs_pkg.sv
hdl/hbs_scan.sv
hdl/hierarchical_bitmap_set_top.sv
tb/hierarchical_bitmap_set_checker.sv
tb/hierarchical_bitmap_set_top_tb.sv
